FILE: rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants for the shake direction detector.
// ----------------------------------------------------------------------------
package sdd_pkg;

    // Datapath widths
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GRAV_WIDTH     = 24;
    localparam int TIME_WIDTH     = 32;
    localparam int ALPHA_WIDTH    = 16;
    localparam int THR_WIDTH      = 15;
    localparam int RATIO_WIDTH    = 12;
    localparam int RATIO_FRAC     = 8;
    localparam int HITS_WIDTH     = 16;
    localparam int COOL_WIDTH     = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Register reset values
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET     = 16'd13107;
    localparam logic [THR_WIDTH-1:0]   THR_RESET       = 15'd1434;
    localparam logic [RATIO_WIDTH-1:0] RATIO_RESET     = 12'd307;
    localparam logic [HITS_WIDTH-1:0]  HITS_RESET      = 16'd3;
    localparam logic [COOL_WIDTH-1:0]  COOL_RESET      = 16'd400;
    localparam logic                   HIGHPASS_RESET  = 1'b1;
    localparam logic                   Z_ENABLE_RESET  = 1'b1;
    localparam logic [1:0]             INVERT_RESET    = 2'd0;

    // Direction codes
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } dir_t;

    // Register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ALPHA     = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_RATIO     = 3'd2,
        CFG_HITS      = 3'd3,
        CFG_COOLDOWN  = 3'd4,
        CFG_HIGHPASS  = 3'd5,
        CFG_Z_ENABLE  = 3'd6,
        CFG_INVERT    = 3'd7
    } cfg_index_t;

    // Register file contents
    typedef struct packed {
        logic [ALPHA_WIDTH-1:0] alpha;
        logic [THR_WIDTH-1:0]   threshold;
        logic [RATIO_WIDTH-1:0] ratio;
        logic [HITS_WIDTH-1:0]  hits_needed;
        logic [COOL_WIDTH-1:0]  cooldown;
        logic                   highpass_en;
        logic                   z_en;
        logic [1:0]             invert;
    } cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic                  is_strong;
        dir_t                  dir;
        logic [TIME_WIDTH-1:0] time_ms;
    } class_item_t;

endpackage

FILE: rtl/sdd_if.sv
// ----------------------------------------------------------------------------
// sdd_if
// Sample and result channels of the shake direction detector.
// ----------------------------------------------------------------------------
interface sdd_in_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [sdd_pkg::SAMPLE_WIDTH-1:0]       accel_x;
    logic signed [sdd_pkg::SAMPLE_WIDTH-1:0]       accel_y;
    logic signed [sdd_pkg::SAMPLE_WIDTH-1:0]       accel_z;
    logic [sdd_pkg::TIME_WIDTH-1:0]                time_ms;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output time_ms, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input time_ms, output ready);
endinterface

interface sdd_out_if;
    logic          valid;
    logic          ready;
    logic          fired;
    sdd_pkg::dir_t fired_direction;
    logic          sample_strong;
    sdd_pkg::dir_t sample_direction;

    modport source (output valid, output fired, output fired_direction,
                    output sample_strong, output sample_direction, input ready);
    modport sink   (input valid, input fired, input fired_direction,
                    input sample_strong, input sample_direction, output ready);
endinterface

FILE: rtl/sdd_front.sv
// ----------------------------------------------------------------------------
// sdd_front
// Accepts samples, runs the gravity filter on a shared multiplier one axis
// at a time, picks the dominant axis and classifies the sample.
// ----------------------------------------------------------------------------
module sdd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    sdd_in_if.sink               in_ch,
    input  sdd_pkg::cfg_t        cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output sdd_pkg::class_item_t push_data
);

    localparam int SAMPLE_WIDTH = sdd_pkg::SAMPLE_WIDTH;
    localparam int GW        = sdd_pkg::GRAV_WIDTH;
    localparam int GRAV_FRAC = GW - SAMPLE_WIDTH;
    localparam int HW        = GW + 1;
    localparam int PW        = HW + sdd_pkg::ALPHA_WIDTH + 1;
    localparam int THR_SW    = sdd_pkg::THR_WIDTH + GRAV_FRAC;
    localparam int CMP_W     = (THR_SW > GW) ? THR_SW : GW;
    localparam int DOM_W     = GW + sdd_pkg::RATIO_WIDTH;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (sdd_pkg::ALPHA_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SORT,
        ST_DOM,
        ST_PUSH
    } state_t;

    // Control and filter state
    state_t               state_reg, state_next;
    logic [1:0]           axis_reg, axis_next;
    logic signed [GW-1:0] grav_reg [0:2];
    logic signed [GW-1:0] grav_next [0:2];

    // Working registers
    logic signed [HW-1:0]             h_reg [0:2];
    logic signed [HW-1:0]             h_next [0:2];
    logic signed [PW-1:0]             prod_reg, prod_next;
    logic [sdd_pkg::TIME_WIDTH-1:0]   time_reg, time_next;
    logic [GW-1:0]                    prim_reg, prim_next;
    logic [GW-1:0]                    sec_reg, sec_next;
    logic [1:0]                       pax_reg, pax_next;
    logic                             ppos_reg, ppos_next;
    logic                             thr_ok_reg, thr_ok_next;
    logic [DOM_W-1:0]                 rhs_reg, rhs_next;

    // Combinational helpers
    logic signed [HW-1:0] diff;
    logic signed [PW-1:0] step;
    logic signed [GW-1:0] grav_new;
    logic signed [HW-1:0] hv [0:2];
    logic [GW-1:0]        mag [0:2];
    logic [1:0]           ax;
    logic [DOM_W-1:0]     lhs;
    logic                 is_strong;
    sdd_pkg::dir_t        dir;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign push_valid  = (state_reg == ST_PUSH);

    // Filter arithmetic for the current axis
    always_comb
    begin
        diff     = h_reg[axis_reg] - HW'(grav_reg[axis_reg]);
        step     = (prod_reg + ROUND_HALF) >>> sdd_pkg::ALPHA_WIDTH;
        grav_new = grav_reg[axis_reg] + GW'(step);
    end

    // Axis magnitudes and dominant axis, ties to the lower axis
    always_comb
    begin
        hv[0] = cfg.invert[0] ? -h_reg[0] : h_reg[0];
        hv[1] = cfg.invert[1] ? -h_reg[1] : h_reg[1];
        hv[2] = h_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = hv[i][HW-1] ? GW'(-hv[i]) : GW'(hv[i]);
        end
        ax = 2'd0;
        if (mag[1] > mag[0])
        begin
            ax = 2'd1;
        end
        if (mag[2] > mag[ax])
        begin
            ax = 2'd2;
        end
    end

    // Strength and direction from the registered compare terms
    always_comb
    begin
        lhs       = DOM_W'(prim_reg) << sdd_pkg::RATIO_FRAC;
        is_strong = thr_ok_reg && ((sec_reg == '0) || (lhs >= rhs_reg));
        dir       = sdd_pkg::DIR_NONE;
        if (is_strong)
        begin
            case (pax_reg)
                2'd0:    dir = ppos_reg ? sdd_pkg::DIR_RIGHT : sdd_pkg::DIR_LEFT;
                2'd1:    dir = ppos_reg ? sdd_pkg::DIR_UP : sdd_pkg::DIR_DOWN;
                default: dir = !cfg.z_en ? sdd_pkg::DIR_NONE :
                               (ppos_reg ? sdd_pkg::DIR_UP : sdd_pkg::DIR_DOWN);
            endcase
        end
        push_data.is_strong = is_strong;
        push_data.dir       = dir;
        push_data.time_ms   = time_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        grav_next   = grav_reg;
        h_next      = h_reg;
        prod_next   = prod_reg;
        time_next   = time_reg;
        prim_next   = prim_reg;
        sec_next    = sec_reg;
        pax_next    = pax_reg;
        ppos_next   = ppos_reg;
        thr_ok_next = thr_ok_reg;
        rhs_next    = rhs_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    h_next[0]  = HW'(in_ch.accel_x) <<< GRAV_FRAC;
                    h_next[1]  = HW'(in_ch.accel_y) <<< GRAV_FRAC;
                    h_next[2]  = HW'(in_ch.accel_z) <<< GRAV_FRAC;
                    time_next  = in_ch.time_ms;
                    axis_next  = 2'd0;
                    state_next = cfg.highpass_en ? ST_MUL : ST_SORT;
                end
            end
            ST_MUL:
            begin
                prod_next  = PW'(diff) * PW'($signed({1'b0, cfg.alpha}));
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                grav_next[axis_reg] = grav_new;
                h_next[axis_reg]    = h_reg[axis_reg] - HW'(grav_new);
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_SORT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_SORT:
            begin
                pax_next    = ax;
                prim_next   = mag[ax];
                ppos_next   = !hv[ax][HW-1] && (hv[ax] != '0);
                thr_ok_next = CMP_W'(mag[ax]) >= (CMP_W'(cfg.threshold) << GRAV_FRAC);
                case (ax)
                    2'd0:    sec_next = (mag[1] > mag[2]) ? mag[1] : mag[2];
                    2'd1:    sec_next = (mag[0] > mag[2]) ? mag[0] : mag[2];
                    default: sec_next = (mag[0] > mag[1]) ? mag[0] : mag[1];
                endcase
                state_next = ST_DOM;
            end
            ST_DOM:
            begin
                rhs_next   = DOM_W'(sec_reg) * DOM_W'(cfg.ratio);
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and gravity estimate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                grav_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            grav_reg  <= grav_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        prod_reg   <= prod_next;
        time_reg   <= time_next;
        prim_reg   <= prim_next;
        sec_reg    <= sec_next;
        pax_reg    <= pax_next;
        ppos_reg   <= ppos_next;
        thr_ok_reg <= thr_ok_next;
        rhs_reg    <= rhs_next;
    end

endmodule

FILE: rtl/sdd_fifo.sv
// ----------------------------------------------------------------------------
// sdd_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module sdd_fifo #(
    parameter int DEPTH = sdd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sdd_pkg::class_item_t push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output sdd_pkg::class_item_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sdd_pkg::class_item_t mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/sdd_back.sv
// ----------------------------------------------------------------------------
// sdd_back
// Counts equal-direction hits, applies the cooldown and drives the result
// output register.
// ----------------------------------------------------------------------------
module sdd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdd_pkg::cfg_t        cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  sdd_pkg::class_item_t pop_data,
    sdd_out_if.source            out_ch
);

    localparam int HITS_W = sdd_pkg::HITS_WIDTH;
    localparam int TIME_W = sdd_pkg::TIME_WIDTH;

    // Detector state
    sdd_pkg::dir_t       last_dir_reg, last_dir_next;
    logic [HITS_W-1:0]   hits_reg, hits_next;
    logic [TIME_W-1:0]   last_fire_reg, last_fire_next;
    logic                out_valid_reg, out_valid_next;

    // Result register
    logic                fired_reg, fired_next;
    sdd_pkg::dir_t       fired_dir_reg, fired_dir_next;
    logic                strong_reg, strong_next;
    sdd_pkg::dir_t       sample_dir_reg, sample_dir_next;

    logic                take;
    logic [HITS_W-1:0]   hits_upd;
    sdd_pkg::dir_t       dir_upd;
    logic [TIME_W-1:0]   elapsed;
    logic                fire;

    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign take      = pop_valid && pop_ready;

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.fired            = fired_reg;
    assign out_ch.fired_direction  = fired_dir_reg;
    assign out_ch.sample_strong    = strong_reg;
    assign out_ch.sample_direction = sample_dir_reg;

    // Hit run and fire decision
    always_comb
    begin
        dir_upd  = last_dir_reg;
        hits_upd = '0;
        if (pop_data.is_strong)
        begin
            if (pop_data.dir == last_dir_reg)
            begin
                hits_upd = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
            end
            else
            begin
                dir_upd  = pop_data.dir;
                hits_upd = HITS_W'(1);
            end
        end
        elapsed = pop_data.time_ms - last_fire_reg;
        fire    = (hits_upd >= cfg.hits_needed) && (elapsed >= TIME_W'(cfg.cooldown));
    end

    always_comb
    begin
        last_dir_next   = last_dir_reg;
        hits_next       = hits_reg;
        last_fire_next  = last_fire_reg;
        out_valid_next  = out_valid_reg;
        fired_next      = fired_reg;
        fired_dir_next  = fired_dir_reg;
        strong_next     = strong_reg;
        sample_dir_next = sample_dir_reg;
        if (take)
        begin
            last_dir_next   = dir_upd;
            hits_next       = fire ? '0 : hits_upd;
            last_fire_next  = fire ? pop_data.time_ms : last_fire_reg;
            out_valid_next  = 1'b1;
            fired_next      = fire;
            fired_dir_next  = fire ? dir_upd : sdd_pkg::DIR_NONE;
            strong_next     = pop_data.is_strong;
            sample_dir_next = pop_data.dir;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dir_reg  <= sdd_pkg::DIR_NONE;
            hits_reg      <= '0;
            last_fire_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_dir_reg  <= last_dir_next;
            hits_reg      <= hits_next;
            last_fire_reg <= last_fire_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg      <= fired_next;
        fired_dir_reg  <= fired_dir_next;
        strong_reg     <= strong_next;
        sample_dir_reg <= sample_dir_next;
    end

endmodule

FILE: rtl/shake_direction_detector.sv
// ----------------------------------------------------------------------------
// shake_direction_detector
// Three-axis shake direction detector with gravity removal, dominant-axis
// classification, hit counting and fire cooldown.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake      | payload
//   in_ch    | in  | valid / ready  | accel_x, accel_y, accel_z, time_ms
//   out_ch   | out | valid / ready  | fired, fired_direction, sample_strong,
//            |     |                | sample_direction
//   cfg      | in  | cfg_we         | cfg_index, cfg_wdata
//
// The front accepts a new sample only after the last item has been pushed
// to the queue; with the gravity filter on, the shared filter multiplier
// runs one multiply and one accumulate step per axis before classification.
// One result item per input item, in order. Reset is asynchronous, active
// low, and restores the control state, configuration and gravity estimates.
// A two-item queue and an output register decouple a stalled output from
// sample intake.
// ----------------------------------------------------------------------------
module shake_direction_detector #(
    parameter int QUEUE_DEPTH  = sdd_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sdd_in_if.sink                              in_ch,
    sdd_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [sdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sdd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    sdd_pkg::cfg_t        cfg_reg, cfg_next;
    logic                 push_valid, push_ready;
    sdd_pkg::class_item_t push_data;
    logic                 pop_valid, pop_ready;
    sdd_pkg::class_item_t pop_data;

    // Configuration register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (sdd_pkg::cfg_index_t'(cfg_index))
                sdd_pkg::CFG_ALPHA:
                    cfg_next.alpha = cfg_wdata[sdd_pkg::ALPHA_WIDTH-1:0];
                sdd_pkg::CFG_THRESHOLD:
                    cfg_next.threshold = cfg_wdata[sdd_pkg::THR_WIDTH-1:0];
                sdd_pkg::CFG_RATIO:
                    cfg_next.ratio = cfg_wdata[sdd_pkg::RATIO_WIDTH-1:0];
                sdd_pkg::CFG_HITS:
                    cfg_next.hits_needed = cfg_wdata[sdd_pkg::HITS_WIDTH-1:0];
                sdd_pkg::CFG_COOLDOWN:
                    cfg_next.cooldown = cfg_wdata[sdd_pkg::COOL_WIDTH-1:0];
                sdd_pkg::CFG_HIGHPASS:
                    cfg_next.highpass_en = cfg_wdata[0];
                sdd_pkg::CFG_Z_ENABLE:
                    cfg_next.z_en = cfg_wdata[0];
                sdd_pkg::CFG_INVERT:
                    cfg_next.invert = cfg_wdata[1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha       <= sdd_pkg::ALPHA_RESET;
            cfg_reg.threshold   <= sdd_pkg::THR_RESET;
            cfg_reg.ratio       <= sdd_pkg::RATIO_RESET;
            cfg_reg.hits_needed <= sdd_pkg::HITS_RESET;
            cfg_reg.cooldown    <= sdd_pkg::COOL_RESET;
            cfg_reg.highpass_en <= sdd_pkg::HIGHPASS_RESET;
            cfg_reg.z_en        <= sdd_pkg::Z_ENABLE_RESET;
            cfg_reg.invert      <= sdd_pkg::INVERT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Filter and classification
    sdd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Classified item queue
    sdd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Hit counting and fire
    sdd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

    // A new sample is never taken in the cycle right after one is accepted
    a_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("sample accepted on two consecutive cycles");

    // A weak sample carries no direction
    a_weak_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.sample_strong |->
        out_ch.sample_direction == sdd_pkg::DIR_NONE)
        else $error("weak sample reported with a direction");

    // No fire, no fire direction
    a_nofire_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.fired |->
        out_ch.fired_direction == sdd_pkg::DIR_NONE)
        else $error("fire direction set without a fire");

endmodule

FILE: tb/sv/shake_direction_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shake_direction_detector_tb
// Self-checking bench for the shake direction detector. A queue-fed driver
// offers accelerometer samples and a clocked monitor predicts each result
// from its own copy of the filter, classifier and hit/cooldown state. Results
// are checked in order, field by field. The run covers directed corner
// samples, random shake bursts and noise under several register settings and
// idle patterns, and a long output stall.
// ----------------------------------------------------------------------------
module shake_direction_detector_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 220;
    localparam int MAX_PRINTS    = 40;
    localparam int SW            = sdd_pkg::SAMPLE_WIDTH;
    localparam int TW            = sdd_pkg::TIME_WIDTH;
    localparam int CFG_W         = sdd_pkg::CFG_DATA_WIDTH;
    localparam int GRAV_SHIFT    = sdd_pkg::GRAV_WIDTH - sdd_pkg::SAMPLE_WIDTH;

    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
        logic [TW-1:0]        t;
    } accel_sample_t;

    typedef struct {
        logic          fired;
        sdd_pkg::dir_t fire_dir;
        logic          is_strong;
        sdd_pkg::dir_t sample_dir;
    } shake_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [sdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_W-1:0]                    cfg_wdata;

    sdd_in_if  sample_bus ();
    sdd_out_if result_bus ();

    shake_direction_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (sample_bus),
        .out_ch    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    accel_sample_t pending_samples[$];
    shake_result_t expected_results[$];

    // Shadow registers and detector state
    sdd_pkg::cfg_t shadow_cfg;
    longint        grav_est [3];
    sdd_pkg::dir_t prev_dir;
    int            hit_run;
    logic [TW-1:0] fire_stamp;

    // Idling control
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_len      = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    logic        in_taken;
    int          idle_cycles = 0;
    int          error_count = 0;
    int          items_in    = 0;
    int          results_out = 0;
    int          fires_seen  = 0;
    int          strong_seen = 0;
    int          cfg_writes  = 0;
    logic [31:0] clock_ms    = '0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_shadow();
        shadow_cfg.alpha       = sdd_pkg::ALPHA_RESET;
        shadow_cfg.threshold   = sdd_pkg::THR_RESET;
        shadow_cfg.ratio       = sdd_pkg::RATIO_RESET;
        shadow_cfg.hits_needed = sdd_pkg::HITS_RESET;
        shadow_cfg.cooldown    = sdd_pkg::COOL_RESET;
        shadow_cfg.highpass_en = sdd_pkg::HIGHPASS_RESET;
        shadow_cfg.z_en        = sdd_pkg::Z_ENABLE_RESET;
        shadow_cfg.invert      = sdd_pkg::INVERT_RESET;
        foreach (grav_est[a])
            grav_est[a] = 0;
        prev_dir   = sdd_pkg::DIR_NONE;
        hit_run    = 0;
        fire_stamp = '0;
    endfunction

    // Gravity tracking for one axis; returns the high-passed value
    function automatic longint highpass_axis(int a, logic signed [SW-1:0] s);
        longint scaled;
        longint step;
        scaled = longint'(s) * (longint'(1) << GRAV_SHIFT);
        if (!shadow_cfg.highpass_en)
            return scaled;
        // round half up, then floor by arithmetic shift
        step = (scaled - grav_est[a]) * longint'(shadow_cfg.alpha) + 32768;
        grav_est[a] = grav_est[a] + (step >>> 16);
        return scaled - grav_est[a];
    endfunction

    function automatic shake_result_t predict_shake(accel_sample_t s);
        shake_result_t r;
        longint        hp [3];
        longint        mag [3];
        longint        primary;
        longint        second;
        int            axis;
        logic          hit;
        sdd_pkg::dir_t dir;
        logic [TW-1:0] elapsed;

        hp[0] = highpass_axis(0, s.x);
        hp[1] = highpass_axis(1, s.y);
        hp[2] = highpass_axis(2, s.z);
        if (shadow_cfg.invert[0])
            hp[0] = -hp[0];
        if (shadow_cfg.invert[1])
            hp[1] = -hp[1];
        foreach (hp[a])
            mag[a] = (hp[a] < 0) ? -hp[a] : hp[a];

        // dominant axis, ties to the lower index
        axis = 0;
        if (mag[1] > mag[axis])
            axis = 1;
        if (mag[2] > mag[axis])
            axis = 2;
        primary = mag[axis];
        second  = 0;
        foreach (mag[a])
            if (a != axis && mag[a] > second)
                second = mag[a];

        hit = (primary >= (longint'(shadow_cfg.threshold) << GRAV_SHIFT)) &&
              (second == 0 || primary * 256 >= second * longint'(shadow_cfg.ratio));

        dir = sdd_pkg::DIR_NONE;
        if (hit)
        begin
            case (axis)
                0:       dir = (hp[0] > 0) ? sdd_pkg::DIR_RIGHT : sdd_pkg::DIR_LEFT;
                1:       dir = (hp[1] > 0) ? sdd_pkg::DIR_UP : sdd_pkg::DIR_DOWN;
                default: dir = !shadow_cfg.z_en ? sdd_pkg::DIR_NONE :
                               (hp[2] > 0) ? sdd_pkg::DIR_UP : sdd_pkg::DIR_DOWN;
            endcase
            if (dir == prev_dir)
            begin
                if (hit_run < 65535)
                    hit_run++;
            end
            else
            begin
                prev_dir = dir;
                hit_run  = 1;
            end
        end
        else
            hit_run = 0;

        r.fired      = 1'b0;
        r.fire_dir   = sdd_pkg::DIR_NONE;
        r.is_strong  = hit;
        r.sample_dir = dir;

        // wrapped cooldown since the last fire
        elapsed = s.t - fire_stamp;
        if (hit_run >= shadow_cfg.hits_needed && elapsed >= shadow_cfg.cooldown)
        begin
            r.fired    = 1'b1;
            r.fire_dir = prev_dir;
            fire_stamp = s.t;
            hit_run    = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: result %0d %s: got %0d, expected %0d",
                     $time, results_out, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sample driver: holds an offered item until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_bus.valid <= 1'b0;
        else if (sample_bus.valid && !in_taken)
        begin
            // still waiting for ready
        end
        else if (pending_samples.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct)
        begin
            sample_bus.valid   <= 1'b1;
            sample_bus.accel_x <= pending_samples[0].x;
            sample_bus.accel_y <= pending_samples[0].y;
            sample_bus.accel_z <= pending_samples[0].z;
            sample_bus.time_ms <= pending_samples[0].t;
        end
        else
            sample_bus.valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls plus requested long hold-offs
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict newly accepted samples
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : track_items
        shake_result_t want;
        accel_sample_t seen;
        logic          in_fire;
        logic          out_fire;

        in_fire  = sample_bus.valid && sample_bus.ready;
        out_fire = result_bus.valid && result_bus.ready;
        if (!rst_n)
        begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_fire)
            begin
                results_out++;
                if (result_bus.fired === 1'b1)
                    fires_seen++;
                if (result_bus.sample_strong === 1'b1)
                    strong_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("arrived with nothing expected", 0, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.fired !== want.fired)
                        report_mismatch("fired", int'(result_bus.fired), int'(want.fired));
                    if (result_bus.fired_direction !== want.fire_dir)
                        report_mismatch("fired_direction", int'(result_bus.fired_direction),
                                        int'(want.fire_dir));
                    if (result_bus.sample_strong !== want.is_strong)
                        report_mismatch("sample_strong", int'(result_bus.sample_strong),
                                        int'(want.is_strong));
                    if (result_bus.sample_direction !== want.sample_dir)
                        report_mismatch("sample_direction", int'(result_bus.sample_direction),
                                        int'(want.sample_dir));
                end
            end
            if (in_fire)
            begin
                seen.x = sample_bus.accel_x;
                seen.y = sample_bus.accel_y;
                seen.z = sample_bus.accel_z;
                seen.t = sample_bus.time_ms;
                expected_results.push_back(predict_shake(seen));
                void'(pending_samples.pop_front());
                items_in++;
            end
            in_taken    <= in_fire;
            idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog on cycles with no item moving
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(sdd_pkg::cfg_index_t idx, logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] junk;
        logic [CFG_W-1:0] word;
        junk = CFG_W'($urandom);
        word = value;
        // bits above each register's width carry junk
        case (idx)
            sdd_pkg::CFG_ALPHA:     shadow_cfg.alpha = word;
            sdd_pkg::CFG_THRESHOLD:
            begin
                word[15] = junk[15];
                shadow_cfg.threshold = word[14:0];
            end
            sdd_pkg::CFG_RATIO:
            begin
                word[15:12] = junk[15:12];
                shadow_cfg.ratio = word[11:0];
            end
            sdd_pkg::CFG_HITS:      shadow_cfg.hits_needed = word;
            sdd_pkg::CFG_COOLDOWN:  shadow_cfg.cooldown = word;
            sdd_pkg::CFG_HIGHPASS:
            begin
                word[15:1] = junk[15:1];
                shadow_cfg.highpass_en = word[0];
            end
            sdd_pkg::CFG_Z_ENABLE:
            begin
                word[15:1] = junk[15:1];
                shadow_cfg.z_en = word[0];
            end
            sdd_pkg::CFG_INVERT:
            begin
                word[15:2] = junk[15:2];
                shadow_cfg.invert = word[1:0];
            end
            default:
                word = value;
        endcase
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic load_config(int alpha, int thr, int ratio, int hits, int cool,
                               int hp, int zen, int inv);
        write_reg(sdd_pkg::CFG_ALPHA, alpha[15:0]);
        write_reg(sdd_pkg::CFG_THRESHOLD, thr[15:0]);
        write_reg(sdd_pkg::CFG_RATIO, ratio[15:0]);
        write_reg(sdd_pkg::CFG_HITS, hits[15:0]);
        write_reg(sdd_pkg::CFG_COOLDOWN, cool[15:0]);
        write_reg(sdd_pkg::CFG_HIGHPASS, hp[15:0]);
        write_reg(sdd_pkg::CFG_Z_ENABLE, zen[15:0]);
        write_reg(sdd_pkg::CFG_INVERT, inv[15:0]);
    endtask

    // style 0: low extremes, 1: high extremes, other: random
    task automatic pick_config(int style);
        int a;
        int t;
        int r;
        int h;
        int c;
        case (style)
            0: load_config(0, 0, 256, 1, 0, $urandom_range(1, 0), $urandom_range(1, 0),
                           $urandom_range(3, 0));
            1: load_config(65535, 32767, 4095, 65535, 65535, 0, 1, 3);
            default:
            begin
                case ($urandom_range(3, 0))
                    0:       a = 0;
                    1:       a = 65535;
                    default: a = $urandom_range(65535, 0);
                endcase
                t = ($urandom_range(3, 0) == 0) ? $urandom_range(32767, 0)
                                                : $urandom_range(3000, 300);
                r = ($urandom_range(1, 0) == 0) ? $urandom_range(4095, 256)
                                                : $urandom_range(400, 256);
                h = ($urandom_range(7, 0) == 0) ? 65535 : $urandom_range(5, 1);
                case ($urandom_range(3, 0))
                    0:       c = 0;
                    1:       c = 65535;
                    default: c = $urandom_range(600, 0);
                endcase
                load_config(a, t, r, h, c, $urandom_range(1, 0), $urandom_range(1, 0),
                            $urandom_range(3, 0));
            end
        endcase
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1:
            begin
                tx_idle_pct  = 79;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 79;
            end
            default:
            begin
                tx_idle_pct  = 26;
                rx_stall_pct = 26;
            end
        endcase
    endtask

    task automatic queue_sample(int x, int y, int z, logic [TW-1:0] t);
        accel_sample_t s;
        s.x = x[15:0];
        s.y = y[15:0];
        s.z = z[15:0];
        s.t = t;
        pending_samples.push_back(s);
    endtask

    // Run of samples dominated by one axis; a broken run flips sign once
    task automatic queue_burst(bit broken, output int len);
        int axis;
        int mag;
        int v;
        int flip_at;
        int comp [3];
        bit neg;
        axis    = $urandom_range(2, 0);
        neg     = ($urandom_range(1, 0) != 0);
        len     = $urandom_range(8, 1);
        mag     = $urandom_range(32767, 2500);
        flip_at = broken ? $urandom_range(len - 1, 0) : -1;
        for (int k = 0; k < len; k++)
        begin
            for (int a = 0; a < 3; a++)
                comp[a] = $urandom_range(1200, 0) - 600;
            v = mag - $urandom_range(mag / 4, 0);
            if (neg ^ (k == flip_at))
                v = -v;
            comp[axis] = v;
            clock_ms   = clock_ms + $urandom_range(150, 1);
            queue_sample(comp[0], comp[1], comp[2], clock_ms);
        end
    endtask

    task automatic queue_random(int n);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 6)
                queue_burst(1'b0, len);
            else if (pick < 8)
                queue_burst(1'b1, len);
            else
            begin
                // full-range noise, with an occasional jump of the timestamp
                if ($urandom_range(4, 0) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(50, 0);
                queue_sample($urandom, $urandom, $urandom, clock_ms);
                len = 1;
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        sample_bus.valid   = 1'b0;
        sample_bus.accel_x = '0;
        sample_bus.accel_y = '0;
        sample_bus.accel_z = '0;
        sample_bus.time_ms = '0;
        result_bus.ready   = 1'b0;
        reset_shadow();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: reset settings, axis extremes, first fire, equal magnitudes
        set_idle(0);
        queue_sample(0, 0, 0, 0);
        queue_sample(32767, 0, 0, 100);
        queue_sample(32767, 0, 0, 200);
        queue_sample(32767, 0, 0, 500);
        queue_sample(-32768, 0, 0, 510);
        queue_sample(0, 32767, 0, 520);
        queue_sample(0, -32768, 0, 530);
        queue_sample(0, 0, 32767, 540);
        queue_sample(0, 0, -32768, 550);
        queue_sample(8000, 8000, 0, 560);
        queue_sample(-32768, -32768, -32768, 570);
        wait_drained();

        // Directed: raw samples, unit ratio, no hits needed, Z off, both axes inverted
        load_config(13107, 1434, 256, 0, 0, 0, 0, 3);
        queue_sample(5000, 5000, 0, 600);
        queue_sample(0, 0, 20000, 610);
        queue_sample(0, 0, 0, 620);
        queue_sample(0, -9000, 0, 630);
        queue_sample(32767, -32768, 0, 640);
        wait_drained();

        // Directed: largest ratio and a cooldown across the timestamp wrap
        load_config(0, 1000, 4095, 1, 100, 0, 1, 0);
        queue_sample(20000, 1200, 0, 32'hFFFF_FFC0);
        queue_sample(20000, 1300, 0, 32'h0000_0010);
        queue_sample(20000, 0, 0, 32'h0000_0020);
        queue_sample(20000, 0, 0, 32'h0000_0030);
        queue_sample(0, 0, -20000, 32'h0000_0040);
        wait_drained();

        // Random phases over settings and idle patterns
        clock_ms = 32'h0000_1000;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            pick_config((p == 1) ? 0 : (p == 2) ? 1 : 2);
            set_idle(p % 4);
            queue_random(PHASE_ITEMS / 2);
            // sender waits here until the block has emptied
            if (p == 3)
                wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            // long output stall so the block backs up into its input
            if (p == 0)
            begin
                hold_len = LONG_HOLD;
                hold_requests++;
            end
            wait_drained();
        end

        $display("Covered %0d samples, %0d results (%0d strong, %0d fires), %0d register writes,",
                 items_in, results_out, strong_seen, fires_seen, cfg_writes);
        $display("four idle patterns and a %0d-cycle output stall", LONG_HOLD);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
